// ===== hdl/mlrq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel ready queue package
// Field widths, operation and status codes, and the level scan result type
// shared by the scheduler core, its level scan and the channel interfaces.
// ----------------------------------------------------------------------------
package mlrq_pkg;

  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int LEVEL_W  = 3;
  localparam int STATUS_W = 2;

  localparam int LEVELS_DEF = 5;
  localparam int SLOTS_DEF  = 64;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_ENQUEUE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_PICK    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STS_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NONE   = 2'd2;

  typedef struct packed {
    logic               found;
    logic               second;
    logic [LEVEL_W-1:0] level;
  } scan_t;

endpackage
`default_nettype wire

// ===== hdl/mlrq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel ready queue channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface mlrq_in_if
  import mlrq_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [SLOT_W-1:0]  task_slot;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, output func, output task_slot, output level, input ready);
  modport sink (input valid, input func, input task_slot, input level, output ready);
endinterface

interface mlrq_out_if
  import mlrq_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   chosen_slot;
  logic [LEVEL_W-1:0]  chosen_level;

  modport source (output valid, output status, output chosen_slot, output chosen_level,
                  input ready);
  modport sink (input valid, input status, input chosen_slot, input chosen_level,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/mlrq_level_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel ready queue level scan
// Finds the level that pick-next serves: the first level still owed service
// in this round, else the first non-empty level once every count has cleared.
// ----------------------------------------------------------------------------
module mlrq_level_scan
  import mlrq_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF,
  parameter int CW     = 7
) (
  input  logic [CW-1:0] len    [LEVELS],
  input  logic [CW-1:0] served [LEVELS],
  output scan_t         res
);

  logic               f1, f2;
  logic [LEVEL_W-1:0] first1, first2;

  always_comb begin
    f1     = 1'b0;
    f2     = 1'b0;
    first1 = '0;
    first2 = '0;
    // Walk downwards so that the lowest matching level wins.
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (served[i] < len[i]) begin
        f1     = 1'b1;
        first1 = LEVEL_W'(i);
      end
      if (len[i] != '0) begin
        f2     = 1'b1;
        first2 = LEVEL_W'(i);
      end
    end
    res.found  = f1 | f2;
    res.second = ~f1;
    res.level  = f1 ? first1 : first2;
  end

endmodule
`default_nettype wire

// ===== hdl/multilevel_ready_queue_scheduler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel ready queue scheduler core
// Per-level doubly linked FIFOs of task slots with round-robin service counts.
// Each request word takes a memory read, then update and write back, before
// its result word is registered; one request is in flight at a time, and the
// update waits while the result register still holds an unaccepted word.
// Reset: after rst_n the slot flag memory is swept, one entry a cycle, over
// all SLOTS entries; requests are held off until the sweep ends.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_scheduler_core
  import mlrq_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF,
  parameter int SLOTS  = SLOTS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mlrq_in_if.sink     in_ch,
  mlrq_out_if.source  out_ch
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = IW + 1;
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_t;

  state_t        state_r;
  logic [IW-1:0] clr_cnt_r;

  // Per-level queue descriptors.
  logic [IW-1:0] head_r   [LEVELS];
  logic [IW-1:0] tail_r   [LEVELS];
  logic [CW-1:0] len_r    [LEVELS];
  logic [CW-1:0] srv_r    [LEVELS];
  logic [IW-1:0] head_nxt [LEVELS];
  logic [IW-1:0] tail_nxt [LEVELS];
  logic [CW-1:0] len_nxt  [LEVELS];
  logic [CW-1:0] srv_nxt  [LEVELS];

  // Slot memories: links, and a queued flag with the slot's level.
  logic [IW-1:0] next_mem [SLOTS];
  logic [IW-1:0] prev_mem [SLOTS];
  logic [LW:0]   info_mem [SLOTS];

  logic [IW-1:0] next_rd_r, prev_rd_r;
  logic [LW:0]   info_rd_r;

  // Request held for the update cycle.
  logic [FUNC_W-1:0] func_r;
  logic [IW-1:0]     slot_r;
  logic              slot_ok_r;
  logic [LW-1:0]     lvl_r;
  logic              lvl_ok_r;

  // Result register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [SLOT_W-1:0]   cslot_r;
  logic [LEVEL_W-1:0]  clvl_r;

  scan_t         scan;
  logic [LW-1:0] scan_lvl;
  logic          in_acc, exec_go;
  logic [IW-1:0] rd_addr;

  logic          nx_we, pv_we, info_we;
  logic [IW-1:0] nx_addr, nx_data, pv_addr, pv_data, info_addr;
  logic [LW:0]   info_data;

  logic          ul_en;
  logic [LW-1:0] ul_lvl;
  logic [IW-1:0] ul_slot;

  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [LEVEL_W-1:0]  res_lvl;

  mlrq_level_scan #(
    .LEVELS (LEVELS),
    .CW     (CW)
  ) u_scan (
    .len    (len_r),
    .served (srv_r),
    .res    (scan)
  );

  assign scan_lvl     = LW'(scan.level);
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign exec_go      = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.chosen_slot  = cslot_r;
  assign out_ch.chosen_level = clvl_r;

  // A pick reads the links of the head it will hand out; the others read
  // the slot named in the request.
  always_comb begin
    if (in_ch.func == FN_PICK) begin
      rd_addr = head_r[scan_lvl];
    end else begin
      rd_addr = IW'(in_ch.task_slot);
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    len_nxt    = len_r;
    srv_nxt    = srv_r;
    nx_we      = 1'b0;
    nx_addr    = '0;
    nx_data    = '0;
    pv_we      = 1'b0;
    pv_addr    = '0;
    pv_data    = '0;
    info_we    = 1'b0;
    info_addr  = '0;
    info_data  = '0;
    ul_en      = 1'b0;
    ul_lvl     = '0;
    ul_slot    = '0;
    res_status = STS_REJECT;
    res_slot   = '0;
    res_lvl    = '0;

    unique case (func_r)
      FN_ENQUEUE: begin
        if (lvl_ok_r && slot_ok_r && !info_rd_r[LW]) begin
          if (len_r[lvl_r] == '0) begin
            head_nxt[lvl_r] = slot_r;
          end else begin
            nx_we   = 1'b1;
            nx_addr = tail_r[lvl_r];
            nx_data = slot_r;
            pv_we   = 1'b1;
            pv_addr = slot_r;
            pv_data = tail_r[lvl_r];
          end
          tail_nxt[lvl_r] = slot_r;
          len_nxt[lvl_r]  = len_r[lvl_r] + CW'(1);
          info_we    = 1'b1;
          info_addr  = slot_r;
          info_data  = {1'b1, lvl_r};
          res_status = STS_DONE;
          res_slot   = SLOT_W'(slot_r);
          res_lvl    = LEVEL_W'(lvl_r);
        end
      end
      FN_PICK: begin
        res_status = STS_NONE;
        // Levels passed over lose their count; a second pass clears them all.
        for (int j = 0; j < LEVELS; j++) begin
          if (!scan.found || scan.second || (LEVEL_W'(j) < scan.level)) begin
            srv_nxt[j] = '0;
          end
        end
        if (scan.found) begin
          srv_nxt[scan_lvl] = scan.second ? CW'(1) : srv_r[scan_lvl] + CW'(1);
          ul_en      = 1'b1;
          ul_lvl     = scan_lvl;
          ul_slot    = head_r[scan_lvl];
          res_status = STS_DONE;
          res_slot   = SLOT_W'(head_r[scan_lvl]);
          res_lvl    = scan.level;
        end
      end
      FN_REMOVE: begin
        res_status = STS_NONE;
        if (slot_ok_r && info_rd_r[LW]) begin
          ul_en      = 1'b1;
          ul_lvl     = info_rd_r[LW-1:0];
          ul_slot    = slot_r;
          res_status = STS_DONE;
          res_slot   = SLOT_W'(slot_r);
          res_lvl    = LEVEL_W'(info_rd_r[LW-1:0]);
        end
      end
      default: begin
        res_status = STS_REJECT;
      end
    endcase

    if (ul_en) begin
      if (len_r[ul_lvl] <= CW'(1)) begin
        head_nxt[ul_lvl] = '0;
        tail_nxt[ul_lvl] = '0;
      end else if (head_r[ul_lvl] == ul_slot) begin
        head_nxt[ul_lvl] = next_rd_r;
      end else if (tail_r[ul_lvl] == ul_slot) begin
        tail_nxt[ul_lvl] = prev_rd_r;
      end else begin
        // Interior slot: splice its neighbours together.
        nx_we   = 1'b1;
        nx_addr = prev_rd_r;
        nx_data = next_rd_r;
        pv_we   = 1'b1;
        pv_addr = next_rd_r;
        pv_data = prev_rd_r;
      end
      if (len_r[ul_lvl] != '0) begin
        len_nxt[ul_lvl] = len_r[ul_lvl] - CW'(1);
      end
      info_we   = 1'b1;
      info_addr = ul_slot;
      info_data = '0;
    end
  end

  // Slot memories.
  always_ff @(posedge clk) begin
    if (exec_go && nx_we) begin
      next_mem[nx_addr] <= nx_data;
    end
    if (exec_go && pv_we) begin
      prev_mem[pv_addr] <= pv_data;
    end
    if (state_r == ST_CLEAR) begin
      info_mem[clr_cnt_r] <= '0;
    end else if (exec_go && info_we) begin
      info_mem[info_addr] <= info_data;
    end
    if (in_acc) begin
      next_rd_r <= next_mem[rd_addr];
      prev_rd_r <= prev_mem[rd_addr];
      info_rd_r <= info_mem[rd_addr];
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r    <= in_ch.func;
      slot_r    <= IW'(in_ch.task_slot);
      slot_ok_r <= int'(in_ch.task_slot) < SLOTS;
      lvl_r     <= LW'(in_ch.level);
      lvl_ok_r  <= int'(in_ch.level) < LEVELS;
    end
  end

  // Control state, level descriptors and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < LEVELS; k++) begin
        head_r[k] <= '0;
        tail_r[k] <= '0;
        len_r[k]  <= '0;
        srv_r[k]  <= '0;
      end
    end else begin
      if (out_valid_r && out_ch.ready && !exec_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + IW'(1);
          if (clr_cnt_r == IW'(SLOTS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            status_r    <= res_status;
            cslot_r     <= res_slot;
            clvl_r      <= res_lvl;
            head_r      <= head_nxt;
            tail_r      <= tail_nxt;
            len_r       <= len_nxt;
            srv_r       <= srv_nxt;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_EXEC))
    else $error("accepted request did not move to the update cycle");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EXEC) && out_valid_r && !out_ch.ready) |=> (state_r == ST_EXEC))
    else $error("update committed while the result register was occupied");

  a_empty_level_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r[0] == '0) |-> ((head_r[0] == '0) && (tail_r[0] == '0)))
    else $error("empty level keeps a stale head or tail");
`endif

endmodule
`default_nettype wire

// ===== sim/ready_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready queue checker
// Watches the request and result channels of the scheduler core, keeps its
// own copy of the per-level FIFOs and service counts, and compares every
// result word with the next predicted one.
// ----------------------------------------------------------------------------
module ready_queue_checker
  import mlrq_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF,
  parameter int SLOTS  = SLOTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mlrq_in_if   in_ch,
  mlrq_out_if  out_ch,
  output int   mismatch_count,
  output int   waiting
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [LEVEL_W-1:0]  level;
  } sched_result_t;

  // Each level is held as a plain FIFO of slots; removal may take any entry.
  logic [SLOT_W-1:0]  level_fifo[LEVELS][$];
  logic [6:0]         serve_count[LEVELS];
  bit                 queued_map[SLOTS];
  logic [LEVEL_W-1:0] home_level[SLOTS];

  sched_result_t expected_results[$];
  sched_result_t want;
  sched_result_t got;
  int            fails;

  function automatic sched_result_t schedule_request(logic [FUNC_W-1:0]  fn,
                                                     logic [SLOT_W-1:0]  slot,
                                                     logic [LEVEL_W-1:0] lv);
    sched_result_t r;
    int            p;
    int            i;
    int            lvl;
    bit            found;
    r = '{STS_REJECT, '0, '0};
    found = 1'b0;
    case (fn)
      FN_ENQUEUE: begin
        if (int'(lv) < LEVELS && int'(slot) < SLOTS && !queued_map[slot]) begin
          level_fifo[lv].push_back(slot);
          home_level[slot] = lv;
          queued_map[slot] = 1'b1;
          r = '{STS_DONE, slot, lv};
        end
      end
      FN_PICK: begin
        r.status = STS_NONE;
        // Two sweeps from the top level: a level that has had its turns is
        // cleared, so the second sweep can serve it again.
        for (p = 0; p < 2 && !found; p++) begin
          for (i = 0; i < LEVELS && !found; i++) begin
            if (int'(serve_count[i]) < level_fifo[i].size()) begin
              r.slot   = level_fifo[i].pop_front();
              r.level  = LEVEL_W'(i);
              r.status = STS_DONE;
              queued_map[r.slot] = 1'b0;
              serve_count[i] = serve_count[i] + 7'd1;
              found = 1'b1;
            end else begin
              serve_count[i] = '0;
            end
          end
        end
      end
      FN_REMOVE: begin
        r.status = STS_NONE;
        if (int'(slot) < SLOTS && queued_map[slot]) begin
          lvl = int'(home_level[slot]);
          for (i = 0; i < level_fifo[lvl].size(); i++) begin
            if (level_fifo[lvl][i] == slot) begin
              level_fifo[lvl].delete(i);
              break;
            end
          end
          queued_map[slot] = 1'b0;
          r = '{STS_DONE, slot, LEVEL_W'(lvl)};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (level_fifo[i]) begin
        level_fifo[i].delete();
        serve_count[i] = '0;
      end
      foreach (queued_map[i]) queued_map[i] = 1'b0;
      expected_results.delete();
      fails = 0;
      mismatch_count <= 0;
      waiting <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(schedule_request(in_ch.func, in_ch.task_slot,
                                                    in_ch.level));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.chosen_slot, out_ch.chosen_level};
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX) begin
            $display("%0t: result word with none expected: status %0d slot %0d level %0d",
                     $time, got.status, got.slot, got.level);
          end
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            fails++;
            if (fails <= REPORT_MAX) begin
              $display("%0t: mismatch: expected status %0d slot %0d level %0d, got status %0d slot %0d level %0d",
                       $time, want.status, want.slot, want.level,
                       got.status, got.slot, got.level);
            end
          end
        end
      end
      mismatch_count <= fails;
      waiting <= expected_results.size();
    end
  end

endmodule

// ===== sim/tb_multilevel_ready_queue_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler core testbench
// Drives directed and random enqueue, pick and remove words with random
// idling on both channels; the checker beside the core judges the results.
// ----------------------------------------------------------------------------
module tb_multilevel_ready_queue_scheduler_core
  import mlrq_pkg::*;
;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1900;
  localparam int QUIET_FROM   = 1750;
  localparam int PHASE_LEN    = 150;
  localparam int STALL_LIMIT  = 1000;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} op_mix_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet = 1'b0;
  int   idle_cycles = 0;
  int   mismatch_count;
  int   waiting;

  mlrq_in_if  req_ch();
  mlrq_out_if res_ch();

  multilevel_ready_queue_scheduler_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch),
    .out_ch(res_ch)
  );

  ready_queue_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (req_ch),
    .out_ch        (res_ch),
    .mismatch_count(mismatch_count),
    .waiting       (waiting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: random stalls and runs of readiness, always ready at the end.
  initial begin
    int n;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (quiet) begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 24);
        res_ch.ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** multilevel_ready_queue_scheduler_core: FAILED **");
      $finish;
    end
  end

  task automatic send_word(logic [FUNC_W-1:0] fn, logic [SLOT_W-1:0] slot,
                           logic [LEVEL_W-1:0] lv);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= fn;
    req_ch.task_slot <= slot;
    req_ch.level     <= lv;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_random_word(op_mix_t mix);
    int                 r;
    int                 enq_to;
    int                 pick_to;
    logic [FUNC_W-1:0]  fn;
    logic [LEVEL_W-1:0] lv;
    case (mix)
      MIX_FILL:     begin enq_to = 70; pick_to = 85; end
      MIX_BALANCED: begin enq_to = 40; pick_to = 75; end
      default:      begin enq_to = 15; pick_to = 75; end
    endcase
    r = $urandom_range(0, 99);
    if (r < enq_to)       fn = FN_ENQUEUE;
    else if (r < pick_to) fn = FN_PICK;
    else if (r < 95)      fn = FN_REMOVE;
    else                  fn = FN_UNUSED;
    // Mostly valid levels, now and then one beyond the last level.
    if ($urandom_range(0, 99) < 8) lv = LEVEL_W'($urandom_range(LEVELS_DEF, 7));
    else                           lv = LEVEL_W'($urandom_range(0, LEVELS_DEF - 1));
    send_word(fn, SLOT_W'($urandom_range(0, 63)), lv);
  endtask

  initial begin
    req_ch.valid     <= 1'b0;
    req_ch.func      <= FN_ENQUEUE;
    req_ch.task_slot <= '0;
    req_ch.level     <= '0;
    rst_n            <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty queues, the unused code, and enqueues both taken and rejected.
    send_word(FN_PICK,    6'd0,  3'd0);
    send_word(FN_REMOVE,  6'd0,  3'd0);
    send_word(FN_UNUSED,  6'd63, 3'd7);
    send_word(FN_ENQUEUE, 6'd0,  3'd0);
    send_word(FN_ENQUEUE, 6'd63, 3'd4);
    send_word(FN_ENQUEUE, 6'd5,  3'd5);
    send_word(FN_ENQUEUE, 6'd42, 3'd7);
    send_word(FN_ENQUEUE, 6'd0,  3'd2);
    // Removal from the middle, the tail and a lone entry.
    send_word(FN_ENQUEUE, 6'd10, 3'd1);
    send_word(FN_ENQUEUE, 6'd11, 3'd1);
    send_word(FN_ENQUEUE, 6'd12, 3'd1);
    send_word(FN_REMOVE,  6'd11, 3'd0);
    send_word(FN_REMOVE,  6'd12, 3'd0);
    send_word(FN_REMOVE,  6'd63, 3'd0);
    // Round robin: the last pick that succeeds needs the second sweep.
    send_word(FN_ENQUEUE, 6'd20, 3'd1);
    send_word(FN_PICK,    6'd0,  3'd0);
    send_word(FN_PICK,    6'd0,  3'd0);
    send_word(FN_PICK,    6'd0,  3'd0);
    send_word(FN_PICK,    6'd0,  3'd0);
    // Removal of the head, then of a slot that has already left.
    send_word(FN_ENQUEUE, 6'd30, 3'd3);
    send_word(FN_ENQUEUE, 6'd31, 3'd3);
    send_word(FN_REMOVE,  6'd30, 3'd0);
    send_word(FN_PICK,    6'd0,  3'd0);
    send_word(FN_REMOVE,  6'd31, 3'd0);

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k >= QUIET_FROM) quiet = 1'b1;
      send_random_word(op_mix_t'((k / PHASE_LEN) % 3));
    end
    req_ch.valid <= 1'b0;

    do @(posedge clk); while (waiting != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** multilevel_ready_queue_scheduler_core: PASSED **");
    end else begin
      $display("** multilevel_ready_queue_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mlrq_pkg.sv
hdl/mlrq_if.sv
hdl/mlrq_level_scan.sv
hdl/multilevel_ready_queue_scheduler_core.sv
sim/ready_queue_checker.sv
sim/tb_multilevel_ready_queue_scheduler_core.sv
